// ===== hdl/dual_quadrature_encoder_speed_unit_macros.svh =====
// Assertion helpers shared by the encoder speed unit.
`ifndef DUAL_QUADRATURE_ENCODER_SPEED_UNIT_MACROS_SVH
`define DUAL_QUADRATURE_ENCODER_SPEED_UNIT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define QDES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define QDES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/qdes_pkg.sv =====
package qdes_pkg;

  // Operation codes carried by in_op.
  typedef enum logic [1:0] {
    OP_PIN  = 2'd0,
    OP_SYNC = 2'd1,
    OP_TICK = 2'd2,
    OP_CLR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WAIT
  } top_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_RUN,
    DV_SAT
  } div_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam int unsigned US_W = 20;
  localparam logic [US_W-1:0] US_PER_SEC = 20'd1000000;
  localparam int unsigned SPD_W = 16;

endpackage

// ===== hdl/qdes_div.sv =====
module qdes_div #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [COUNT_WIDTH-1:0] delta,
  input  logic [TIME_WIDTH-1:0]         dt,
  output qdes_pkg::div_stat_t           stat,
  output logic signed [15:0]            speed
);
  import qdes_pkg::*;

  localparam int unsigned NW    = COUNT_WIDTH + US_W;
  localparam int unsigned CNT_W = $clog2(NW + 1);

  div_state_t state_r, state_nxt;

  logic [COUNT_WIDTH-1:0] mag_r;
  logic                   neg_r;
  logic [TIME_WIDTH-1:0]  dt_r;
  logic [NW-1:0]          dvd_r;
  logic [TIME_WIDTH-1:0]  rem_r;
  logic [14:0]            q_r;
  logic                   ovf_r;
  logic [CNT_W-1:0]       cnt_r;
  logic signed [15:0]     speed_r;

  logic [TIME_WIDTH:0] rem_sh;
  logic [TIME_WIDTH:0] rem_sub;
  logic                ge;
  logic [NW-1:0]       prod;

  // one restoring step: bring in the next dividend bit, subtract when it fits
  assign rem_sh  = {rem_r, dvd_r[NW-1]};
  assign rem_sub = rem_sh - {1'b0, dt_r};
  assign ge      = (rem_sh >= {1'b0, dt_r});
  assign prod    = NW'(mag_r) * NW'(US_PER_SEC);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE: if (start) state_nxt = DV_MUL;
      DV_MUL:  state_nxt = DV_RUN;
      DV_RUN:  if (cnt_r == CNT_W'(1)) state_nxt = DV_SAT;
      DV_SAT:  state_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = (state_r != DV_IDLE);
    stat.done = (state_r == DV_SAT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      DV_IDLE: begin
        if (start) begin
          neg_r <= delta[COUNT_WIDTH-1];
          mag_r <= delta[COUNT_WIDTH-1] ? $unsigned(-delta) : $unsigned(delta);
          dt_r  <= dt;
        end
      end
      DV_MUL: begin
        dvd_r <= prod;
        rem_r <= '0;
        q_r   <= '0;
        ovf_r <= 1'b0;
        cnt_r <= CNT_W'(NW);
      end
      DV_RUN: begin
        rem_r <= ge ? rem_sub[TIME_WIDTH-1:0] : rem_sh[TIME_WIDTH-1:0];
        dvd_r <= dvd_r << 1;
        q_r   <= {q_r[13:0], ge};
        ovf_r <= ovf_r | q_r[14];
        cnt_r <= cnt_r - CNT_W'(1);
      end
      DV_SAT: begin
        // clamp to the 16-bit signed range
        if (neg_r) begin
          speed_r <= ovf_r ? 16'sh8000 : -$signed({1'b0, q_r});
        end else begin
          speed_r <= (ovf_r || (q_r == 15'h7fff)) ? 16'sh7fff : $signed({1'b0, q_r});
        end
      end
    endcase
  end

  assign speed = speed_r;

endmodule

// ===== hdl/dual_quadrature_encoder_speed_unit.sv =====
// Channel  Handshake          Word
// -------  -----------------  ---------------------------------------------------
// in       in_valid/in_ready  op, channel, xor_level, b_level, time_us
// out      out_valid/out_ready total_left/right, speed_left/right, error_left/right
//
// Pin sample, resync and error clear give their word in the cycle after acceptance.
// A run tick is divided by two bit-serial dividers, one per encoder, that shift
// COUNT_WIDTH+20 dividend bits each; no word is taken until the tick's word loads.
// Reset (rst_n low, synchronous) clears all encoder state; the first word after
// it may be accepted in the next cycle. A run tick is taken while a word still
// waits on out; other ops wait for the output register to free.
`include "dual_quadrature_encoder_speed_unit_macros.svh"

module dual_quadrature_encoder_speed_unit #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic               in_channel,
  input  logic               in_xor_level,
  input  logic               in_b_level,
  input  logic [31:0]        in_time_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_total_left,
  output logic signed [15:0] out_total_right,
  output logic signed [15:0] out_speed_left,
  output logic signed [15:0] out_speed_right,
  output logic               out_error_left,
  output logic               out_error_right
);
  import qdes_pkg::*;

  top_state_t state_r, state_nxt;

  // per-encoder state, index 0 left, 1 right
  logic [1:0]             prev_a_r, prev_a_nxt;
  logic [1:0]             prev_b_r, prev_b_nxt;
  logic [1:0]             prev_x_r, prev_x_nxt;
  logic [1:0]             fault_r, fault_nxt;
  logic [COUNT_WIDTH-1:0] ivl_r [2];
  logic [COUNT_WIDTH-1:0] ivl_nxt [2];
  logic [COUNT_WIDTH-1:0] total_r [2];
  logic [COUNT_WIDTH-1:0] total_nxt [2];
  logic signed [15:0]     rate_r [2];
  logic [TIME_WIDTH-1:0]  last_tick_r, last_tick_nxt;
  logic                   tick_seen_r, tick_seen_nxt;
  logic                   zero_spd_r, zero_spd_nxt;

  logic                   out_valid_r;
  logic signed [15:0]     o_total_r [2];
  logic signed [15:0]     o_speed_r [2];
  logic [1:0]             o_err_r;

  logic                   slot_free;
  logic                   accept;
  logic                   div_start;
  logic                   out_load;
  logic [TIME_WIDTH-1:0]  dt;
  div_stat_t              st_l, st_r;
  logic signed [15:0]     spd_l, spd_r;

  assign slot_free = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign dt        = in_time_us[TIME_WIDTH-1:0] - last_tick_r;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && (op_t'(in_op) == OP_TICK)) state_nxt = ST_DIV;
      ST_DIV:  if (st_l.done) state_nxt = ST_WAIT;
      ST_WAIT: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // a tick leaves no word at once, so it need not wait for out
        in_ready  = slot_free || (op_t'(in_op) == OP_TICK);
        div_start = accept && (op_t'(in_op) == OP_TICK);
        out_load  = accept && (op_t'(in_op) != OP_TICK);
      end
      ST_DIV: begin
      end
      ST_WAIT: begin
        out_load = slot_free;
      end
      default: begin
      end
    endcase
  end

  // ---------------- encoder state update ----------------
  always_comb begin
    logic a_new;
    logic up;
    logic dn;
    prev_a_nxt    = prev_a_r;
    prev_b_nxt    = prev_b_r;
    prev_x_nxt    = prev_x_r;
    fault_nxt     = fault_r;
    ivl_nxt       = ivl_r;
    total_nxt     = total_r;
    last_tick_nxt = last_tick_r;
    tick_seen_nxt = tick_seen_r;
    zero_spd_nxt  = zero_spd_r;
    a_new         = in_xor_level ^ in_b_level;
    up            = 1'b0;
    dn            = 1'b0;
    if (accept) begin
      for (int i = 0; i < 2; i++) begin
        up = a_new ^ prev_b_r[i];
        dn = prev_a_r[i] ^ in_b_level;
        unique case (op_t'(in_op))
          OP_PIN: begin
            // count only when the xor line moved
            if ((in_channel == 1'(i)) && (in_xor_level != prev_x_r[i])) begin
              if (up && !dn) begin
                ivl_nxt[i] = ivl_r[i] + COUNT_WIDTH'(1);
              end else if (dn && !up) begin
                ivl_nxt[i] = ivl_r[i] - COUNT_WIDTH'(1);
              end
              if ((prev_a_r[i] ^ a_new) && (prev_b_r[i] ^ in_b_level)) begin
                fault_nxt[i] = 1'b1;
              end
              prev_a_nxt[i] = a_new;
              prev_b_nxt[i] = in_b_level;
              prev_x_nxt[i] = in_xor_level;
            end
          end
          OP_SYNC: begin
            if (in_channel == 1'(i)) begin
              prev_a_nxt[i] = a_new;
              prev_b_nxt[i] = in_b_level;
              prev_x_nxt[i] = in_xor_level;
              ivl_nxt[i]    = '0;
              fault_nxt[i]  = 1'b0;
            end
          end
          OP_TICK: begin
            total_nxt[i] = total_r[i] + ivl_r[i];
            ivl_nxt[i]   = '0;
          end
          OP_CLR: begin
            fault_nxt[i] = 1'b0;
          end
        endcase
      end
      if (op_t'(in_op) == OP_TICK) begin
        last_tick_nxt = in_time_us[TIME_WIDTH-1:0];
        tick_seen_nxt = 1'b1;
        zero_spd_nxt  = !tick_seen_r || (dt == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_a_r    <= '0;
      prev_b_r    <= '0;
      prev_x_r    <= '0;
      fault_r     <= '0;
      ivl_r       <= '{default: '0};
      total_r     <= '{default: '0};
      rate_r      <= '{default: '0};
      last_tick_r <= '0;
      tick_seen_r <= 1'b0;
      zero_spd_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_a_r    <= prev_a_nxt;
      prev_b_r    <= prev_b_nxt;
      prev_x_r    <= prev_x_nxt;
      fault_r     <= fault_nxt;
      ivl_r       <= ivl_nxt;
      total_r     <= total_nxt;
      last_tick_r <= last_tick_nxt;
      tick_seen_r <= tick_seen_nxt;
      zero_spd_r  <= zero_spd_nxt;
      // latch the new speeds when the tick word goes out
      if (out_load && (state_r == ST_WAIT)) begin
        rate_r[0] <= zero_spd_r ? 16'sd0 : spd_l;
        rate_r[1] <= zero_spd_r ? 16'sd0 : spd_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < 2; i++) begin
        o_total_r[i] <= $signed(16'(total_nxt[i]));
        if (state_r == ST_WAIT) begin
          o_speed_r[i] <= zero_spd_r ? 16'sd0 : ((i == 0) ? spd_l : spd_r);
        end else begin
          o_speed_r[i] <= rate_r[i];
        end
      end
      // a clear reports the flags as they stood before it
      o_err_r <= ((state_r == ST_IDLE) && (op_t'(in_op) == OP_CLR)) ? fault_r : fault_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_total_left  = o_total_r[0];
  assign out_total_right = o_total_r[1];
  assign out_speed_left  = o_speed_r[0];
  assign out_speed_right = o_speed_r[1];
  assign out_error_left  = o_err_r[0];
  assign out_error_right = o_err_r[1];

  // ---------------- speed dividers ----------------
  qdes_div #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_div_l (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .delta($signed(ivl_r[0])),
    .dt   (dt),
    .stat (st_l),
    .speed(spd_l)
  );

  qdes_div #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_div_r (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .delta($signed(ivl_r[1])),
    .dt   (dt),
    .stat (st_r),
    .speed(spd_r)
  );

  // ---------------- checks ----------------
  `QDES_ASSERT_NOW(a_lockstep, clk, rst_n, st_l.busy || st_r.busy, st_l == st_r, "out of step")
  `QDES_ASSERT_NEXT(a_start, clk, rst_n, div_start, state_r == ST_DIV && st_l.busy, "no division")
  `QDES_ASSERT_NOW(a_done_in_div, clk, rst_n, st_l.done, state_r == ST_DIV, "done outside tick")

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import qdes_pkg::*;

  // One expected output word: totals, speeds and error flags of both encoders.
  typedef struct packed {
    logic signed [15:0] total_left;
    logic signed [15:0] total_right;
    logic signed [15:0] speed_left;
    logic signed [15:0] speed_right;
    logic               error_left;
    logic               error_right;
  } enc_word_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Input channel, driven from the stimulus tasks.
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = OP_PIN;
  logic        in_channel = 1'b0;
  logic        in_xor_level = 1'b0;
  logic        in_b_level = 1'b0;
  logic [31:0] in_time_us = '0;

  // Output channel.
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_total_left;
  logic signed [15:0] out_total_right;
  logic signed [15:0] out_speed_left;
  logic signed [15:0] out_speed_right;
  logic               out_error_left;
  logic               out_error_right;

  // Expected words in order of acceptance, and the failure count.
  enc_word_t   pending_words[$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;

  // While set, neither side idles.
  bit calm = 1'b0;

  // Decoder state mirrored by the predictor, per encoder where indexed.
  logic        pin_a[2];
  logic        pin_b[2];
  logic        pin_x[2];
  logic [15:0] span_count[2];
  logic [15:0] sum_count[2];
  logic signed [15:0] rate_now[2];
  logic        err_flag[2];
  logic [31:0] tick_stamp;
  logic        ticked;

  // Pin levels the stimulus believes each encoder sits at, and the timestamp
  // of the last run tick.
  bit          enc_a[2];
  bit          enc_b[2];
  logic [31:0] now_us = '0;

  dual_quadrature_encoder_speed_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_channel     (in_channel),
    .in_xor_level   (in_xor_level),
    .in_b_level     (in_b_level),
    .in_time_us     (in_time_us),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_total_left (out_total_left),
    .out_total_right(out_total_right),
    .out_speed_left (out_speed_left),
    .out_speed_right(out_speed_right),
    .out_error_left (out_error_left),
    .out_error_right(out_error_right)
  );

  // Period of 2: high for 1, low for 1.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Generous run limit, well above the slowest legal run.
  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

  // Counts per second from a signed interval count and an elapsed time in
  // microseconds; truncate toward zero, saturate to 16 bits.
  function automatic logic signed [15:0] rate_of(logic signed [15:0] delta,
                                                 logic [31:0] dt);
    longint d;
    longint mag;
    if (dt == 0) return '0;
    d = longint'(delta);
    mag = ((d < 0) ? -d : d) * 64'sd1000000 / longint'(dt);
    if (d < 0) return (mag >= 32768) ? 16'sh8000 : 16'(-mag);
    return (mag >= 32767) ? 16'sh7fff : 16'(mag);
  endfunction

  // Advance the mirrored state by one accepted word and return the output
  // word that it should produce.
  function automatic enc_word_t predict_word(op_t op, logic ch, logic x, logic b,
                                             logic [31:0] t);
    enc_word_t   w;
    logic        a;
    logic [15:0] step;
    logic [31:0] dt;
    logic        err_l;
    logic        err_r;
    case (op)
      OP_PIN: begin
        // Ignore the sample unless the xor line moved.
        if (x != pin_x[ch]) begin
          a = x ^ b;
          step = 16'(int'(a ^ pin_b[ch]) - int'(pin_a[ch] ^ b));
          span_count[ch] = span_count[ch] + step;
          if ((pin_a[ch] ^ a) & (pin_b[ch] ^ b)) err_flag[ch] = 1'b1;
          pin_a[ch] = a;
          pin_b[ch] = b;
          pin_x[ch] = x;
        end
      end
      OP_SYNC: begin
        pin_b[ch] = b;
        pin_a[ch] = x ^ b;
        pin_x[ch] = x;
        span_count[ch] = '0;
        err_flag[ch] = 1'b0;
      end
      OP_TICK: begin
        dt = t - tick_stamp;
        for (int i = 0; i < 2; i++) begin
          rate_now[i] = ticked ? rate_of(signed'(span_count[i]), dt) : '0;
          sum_count[i] = sum_count[i] + span_count[i];
          span_count[i] = '0;
        end
        tick_stamp = t;
        ticked = 1'b1;
      end
      default: ;
    endcase
    // Report error flags as they stand before a read-and-clear.
    err_l = err_flag[0];
    err_r = err_flag[1];
    if (op == OP_CLR) begin
      err_flag[0] = 1'b0;
      err_flag[1] = 1'b0;
    end
    w.total_left  = sum_count[0];
    w.total_right = sum_count[1];
    w.speed_left  = rate_now[0];
    w.speed_right = rate_now[1];
    w.error_left  = err_l;
    w.error_right = err_r;
    return w;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor both handshakes at each rising edge: predict on every accepted
  // input word, compare every accepted output word with the oldest one.
  always @(posedge clk) begin
    enc_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        pending_words.push_back(predict_word(op_t'(in_op), in_channel, in_xor_level,
                                             in_b_level, in_time_us));
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          $error("output word with no expected word waiting");
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          check_field("total_left", int'(want.total_left), int'(out_total_left));
          check_field("total_right", int'(want.total_right), int'(out_total_right));
          check_field("speed_left", int'(want.speed_left), int'(out_speed_left));
          check_field("speed_right", int'(want.speed_right), int'(out_speed_right));
          check_field("error_left", int'(want.error_left), int'(out_error_left));
          check_field("error_right", int'(want.error_right), int'(out_error_right));
        end
      end
    end
  end

  // Receiver: stall at random about 13 percent of the time, never while calm.
  always @(posedge clk)
    out_ready <= calm || ($urandom_range(99) >= 13);

  // Drive one word and hold it until accepted. Idle first, now and then.
  task automatic send_word(op_t op, logic ch, logic x, logic b, logic [31:0] t);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_channel   <= ch;
    in_xor_level <= x;
    in_b_level   <= b;
    in_time_us   <= t;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Move one encoder a quarter cycle along the Gray sequence 00,01,11,10.
  task automatic step_encoder(bit ch, bit fwd);
    if ((enc_a[ch] == enc_b[ch]) == fwd) enc_b[ch] = !enc_b[ch];
    else enc_a[ch] = !enc_a[ch];
    send_word(OP_PIN, ch, enc_a[ch] ^ enc_b[ch], enc_b[ch], $urandom);
  endtask

  task automatic sync_encoder(bit ch, bit a, bit b);
    enc_a[ch] = a;
    enc_b[ch] = b;
    send_word(OP_SYNC, ch, a ^ b, b, $urandom);
  endtask

  task automatic tick_at(logic [31:0] t);
    now_us = t;
    send_word(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)), t);
  endtask

  // Error flags read clear straight out of reset; first tick gives zero speed.
  task automatic test_reset_state();
    send_word(OP_CLR, 1'b0, 1'b0, 1'b0, '0);
    tick_at(32'd1000);
  endtask

  // Count both ways on both encoders.
  task automatic test_counting();
    sync_encoder(1'b0, 1'b0, 1'b0);
    repeat (3) step_encoder(1'b0, 1'b1);
    step_encoder(1'b0, 1'b0);
    sync_encoder(1'b1, 1'b0, 1'b1);
    repeat (2) step_encoder(1'b1, 1'b1);
    step_encoder(1'b1, 1'b0);
  endtask

  // Both lines moving at once (which keeps xor still), then an xor move on the right encoder.
  task automatic test_ignored_samples();
    send_word(OP_PIN, 1'b0, enc_a[0] ^ enc_b[0], !enc_b[0], 32'hFFFF_FFFF);
    send_word(OP_PIN, 1'b1, enc_a[1] ^ enc_b[1], !enc_b[1], '0);
    send_word(OP_PIN, 1'b1, !(enc_a[1] ^ enc_b[1]), !enc_b[1], '0);
    enc_a[1] = !enc_a[1];
    enc_b[1] = !enc_b[1];
  endtask

  // Resync drops the interval count but keeps total and speed.
  task automatic test_resync();
    repeat (2) step_encoder(1'b1, 1'b1);
    sync_encoder(1'b1, 1'b1, 1'b1);
    tick_at(now_us + 32'd2000);
  endtask

  // Zero interval, saturation both ways, timestamp wrap and a huge interval.
  task automatic test_speed_limits();
    tick_at(now_us);
    step_encoder(1'b0, 1'b1);
    step_encoder(1'b1, 1'b0);
    tick_at(now_us + 32'd10);
    step_encoder(1'b0, 1'b0);
    step_encoder(1'b1, 1'b1);
    tick_at(now_us + 32'd10);
    tick_at(32'hFFFF_FF00);
    repeat (3) step_encoder(1'b0, 1'b1);
    tick_at(32'h0000_0100);
    step_encoder(1'b1, 1'b1);
    tick_at(now_us + 32'hF000_0000);
    send_word(OP_CLR, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
  endtask

  // Hold the sender until every expected word has drained, then resume.
  task automatic test_drain_pause();
    repeat (4) step_encoder(1'b0, 1'b1);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    tick_at(now_us + 32'd40000);
  endtask

  // Mostly well-formed bursts of quadrature steps followed by ticks, with
  // resyncs, clears and raw noise mixed in.
  task automatic test_random_traffic(int unsigned count);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    bit          ch;
    bit          fwd;
    op_t         op;
    logic [31:0] t;
    start = words_sent;
    while (words_sent - start < count) begin
      calm = (words_sent - start >= 600) && (words_sent - start < 900);
      pick = $urandom_range(99);
      if (pick < 70) begin
        ch = 1'($urandom_range(1));
        fwd = 1'($urandom_range(1));
        len = $urandom_range(16, 1);
        repeat (len) begin
          if ($urandom_range(9) == 0) fwd = !fwd;
          step_encoder(ch, fwd);
        end
        if ($urandom_range(2) == 0) tick_at(now_us + 32'($urandom_range(200000, 500)));
      end else if (pick < 80) begin
        case ($urandom_range(4))
          0: tick_at(now_us);
          1: tick_at(now_us + 32'($urandom_range(40, 1)));
          2: tick_at(now_us + 32'($urandom_range(5000, 41)));
          3: tick_at(now_us + $urandom);
          default: tick_at($urandom);
        endcase
      end else if (pick < 85) begin
        sync_encoder(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (pick < 90) begin
        send_word(OP_CLR, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), $urandom);
      end else begin
        // Raw noise: any op, any levels; track the levels it leaves behind.
        op = op_t'($urandom_range(3));
        ch = 1'($urandom_range(1));
        t = $urandom;
        enc_b[ch] = 1'($urandom_range(1));
        enc_a[ch] = 1'($urandom_range(1));
        if (op == OP_TICK) now_us = t;
        send_word(op, ch, enc_a[ch] ^ enc_b[ch], enc_b[ch], t);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    // Predictor starts from the reset state.
    for (int i = 0; i < 2; i++) begin
      pin_a[i] = 1'b0;
      pin_b[i] = 1'b0;
      pin_x[i] = 1'b0;
      span_count[i] = '0;
      sum_count[i] = '0;
      rate_now[i] = '0;
      err_flag[i] = 1'b0;
      enc_a[i] = 1'b0;
      enc_b[i] = 1'b0;
    end
    tick_stamp = '0;
    ticked = 1'b0;

    // Hold reset low from the start, then release it once.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_counting();
    test_ignored_samples();
    test_resync();
    test_speed_limits();
    test_drain_pause();
    test_random_traffic(1850);

    // Drain: wait for every expected word, then idle on so any stray output word is checked.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/qdes_pkg.sv
hdl/qdes_div.sv
hdl/dual_quadrature_encoder_speed_unit.sv
tb/testbench.sv
